// ----- hw/rtl/segi_pkg.sv -----
// ----------------------------------------------------------------------------
// segi_pkg: shared types and widths for the segment intersection engine
// Holds the coordinate width, the derived arithmetic widths and the record
// that passes from the classifier front end to the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

package segi_pkg;

    // Width of every coordinate.
    localparam int COORD_BITS = 12;

    // Signed coordinate difference.
    localparam int DIFF_W = COORD_BITS + 1;
    // Signed determinant.
    localparam int DET_W  = 2 * COORD_BITS + 2;
    // Magnitude of the determinant.
    localparam int DMAG_W = 2 * COORD_BITS + 1;
    // Signed cross product of one segment's endpoints.
    localparam int PRD_W  = 2 * COORD_BITS + 1;
    // Signed numerators of the crossing point.
    localparam int NUM_W  = 3 * COORD_BITS + 2;

    // Queue depth between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified segment pair: numerators already sign-normalized so that
    // the determinant magnitude is the positive denominator.
    typedef struct packed {
        logic              hit;
        logic [NUM_W-1:0]  num_x;
        logic [NUM_W-1:0]  num_y;
        logic [DMAG_W-1:0] den;
    } t_work;

endpackage

`default_nettype wire

// ----- hw/rtl/segi_front.sv -----
// ----------------------------------------------------------------------------
// segi_front: classifier pipeline
// Six-stage pipeline that forms the determinant and the crossing numerators,
// normalizes the sign and tests the point against both bounding boxes.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_en,
    input  wire                         i_valid,
    input  wire [segi_pkg::COORD_BITS-1:0] i_ax1,
    input  wire [segi_pkg::COORD_BITS-1:0] i_ax2,
    input  wire [segi_pkg::COORD_BITS-1:0] i_ay1,
    input  wire [segi_pkg::COORD_BITS-1:0] i_ay2,
    input  wire [segi_pkg::COORD_BITS-1:0] i_bx1,
    input  wire [segi_pkg::COORD_BITS-1:0] i_bx2,
    input  wire [segi_pkg::COORD_BITS-1:0] i_by1,
    input  wire [segi_pkg::COORD_BITS-1:0] i_by2,
    output logic                        o_valid,
    output segi_pkg::t_work             o_work
);
    import segi_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int BP = C + DMAG_W;

    logic [5:0] r_v;

    // Bounds carried down the pipeline: 0..3 = ax, bx, ay, by low; 4..7 high.
    logic [C-1:0] r_b1 [8];
    logic [C-1:0] r_b2 [8];
    logic [C-1:0] r_b3 [8];
    logic [C-1:0] r_b4 [8];

    // Stage 1 registers.
    logic signed [DIFF_W-1:0] r_adx1, r_ady1, r_bdx1, r_bdy1;
    logic signed [DET_W-1:0]  r_m1, r_m2;
    logic [2*C-1:0]           r_pa1, r_pa2, r_pb1, r_pb2;
    // Stage 2 registers.
    logic signed [DIFF_W-1:0] r_adx2, r_ady2, r_bdx2, r_bdy2;
    logic signed [DET_W-1:0]  r_d2;
    logic signed [PRD_W-1:0]  r_pa, r_pb;
    // Stage 3 registers.
    logic signed [DET_W-1:0]  r_d3;
    logic signed [NUM_W-1:0]  r_nx1, r_nx2, r_ny1, r_ny2;
    // Stage 4 registers.
    logic                     r_nz4;
    logic [DMAG_W-1:0]        r_dm4;
    logic signed [NUM_W-1:0]  r_nx4, r_ny4;
    // Stage 5 registers.
    logic                     r_nz5;
    logic [DMAG_W-1:0]        r_dm5;
    logic signed [NUM_W-1:0]  r_nx5, r_ny5;
    logic [BP-1:0]            r_bp5 [8];
    // Stage 6 registers.
    t_work                    r_out;

    logic [C-1:0]             n_b1 [8];
    logic signed [DIFF_W-1:0] n_adx, n_ady, n_bdx, n_bdy;
    logic signed [NUM_W-1:0]  n_b [8];
    logic                     n_in [4];

    // Differences and bounding boxes of the input segments.
    always_comb begin
        n_adx = $signed({1'b0, i_ax1}) - $signed({1'b0, i_ax2});
        n_ady = $signed({1'b0, i_ay1}) - $signed({1'b0, i_ay2});
        n_bdx = $signed({1'b0, i_bx1}) - $signed({1'b0, i_bx2});
        n_bdy = $signed({1'b0, i_by1}) - $signed({1'b0, i_by2});
        n_b1[0] = (i_ax1 < i_ax2) ? i_ax1 : i_ax2;
        n_b1[4] = (i_ax1 < i_ax2) ? i_ax2 : i_ax1;
        n_b1[1] = (i_bx1 < i_bx2) ? i_bx1 : i_bx2;
        n_b1[5] = (i_bx1 < i_bx2) ? i_bx2 : i_bx1;
        n_b1[2] = (i_ay1 < i_ay2) ? i_ay1 : i_ay2;
        n_b1[6] = (i_ay1 < i_ay2) ? i_ay2 : i_ay1;
        n_b1[3] = (i_by1 < i_by2) ? i_by1 : i_by2;
        n_b1[7] = (i_by1 < i_by2) ? i_by2 : i_by1;
    end

    // Bound tests on the sign-normalized numerators.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            n_b[k] = $signed({{(NUM_W-BP){1'b0}}, r_bp5[k]});
        end
        n_in[0] = (r_nx5 >= n_b[0]) && (r_nx5 <= n_b[4]);
        n_in[1] = (r_nx5 >= n_b[1]) && (r_nx5 <= n_b[5]);
        n_in[2] = (r_ny5 >= n_b[2]) && (r_ny5 <= n_b[6]);
        n_in[3] = (r_ny5 >= n_b[3]) && (r_ny5 <= n_b[7]);
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // Datapath: all stages advance together.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Stage 1: differences and first products.
            r_adx1 <= n_adx;
            r_ady1 <= n_ady;
            r_bdx1 <= n_bdx;
            r_bdy1 <= n_bdy;
            r_m1   <= n_adx * n_bdy;
            r_m2   <= n_ady * n_bdx;
            r_pa1  <= i_ax1 * i_ay2;
            r_pa2  <= i_ay1 * i_ax2;
            r_pb1  <= i_bx1 * i_by2;
            r_pb2  <= i_by1 * i_bx2;
            r_b1   <= n_b1;
            // Stage 2: determinant and endpoint cross products.
            r_adx2 <= r_adx1;
            r_ady2 <= r_ady1;
            r_bdx2 <= r_bdx1;
            r_bdy2 <= r_bdy1;
            r_d2   <= r_m1 - r_m2;
            r_pa   <= $signed({1'b0, r_pa1}) - $signed({1'b0, r_pa2});
            r_pb   <= $signed({1'b0, r_pb1}) - $signed({1'b0, r_pb2});
            r_b2   <= r_b1;
            // Stage 3: numerator products.
            r_d3   <= r_d2;
            r_nx1  <= r_pa * r_bdx2;
            r_nx2  <= r_adx2 * r_pb;
            r_ny1  <= r_pa * r_bdy2;
            r_ny2  <= r_ady2 * r_pb;
            r_b3   <= r_b2;
            // Stage 4: numerators with the sign of the determinant folded in.
            r_nz4  <= (r_d3 != '0);
            r_dm4  <= r_d3[DET_W-1] ? DMAG_W'(-r_d3) : DMAG_W'(r_d3);
            r_nx4  <= r_d3[DET_W-1] ? (r_nx2 - r_nx1) : (r_nx1 - r_nx2);
            r_ny4  <= r_d3[DET_W-1] ? (r_ny2 - r_ny1) : (r_ny1 - r_ny2);
            r_b4   <= r_b3;
            // Stage 5: bounds scaled by the denominator.
            r_nz5  <= r_nz4;
            r_dm5  <= r_dm4;
            r_nx5  <= r_nx4;
            r_ny5  <= r_ny4;
            for (int k = 0; k < 8; k++) begin
                r_bp5[k] <= BP'(r_b4[k]) * BP'(r_dm4);
            end
            // Stage 6: hit decision.
            r_out.hit   <= r_nz5 && n_in[0] && n_in[1] && n_in[2] && n_in[3];
            r_out.num_x <= r_nx5;
            r_out.num_y <= r_ny5;
            r_out.den   <= r_dm5;
        end
    end

    assign o_valid = r_v[5];
    assign o_work  = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/segi_queue.sv -----
// ----------------------------------------------------------------------------
// segi_queue: work queue between front and back
// Small register FIFO that lets the classifier and the divider stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  segi_pkg::t_work  i_data,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_empty,
    output segi_pkg::t_work  o_data
);
    import segi_pkg::*;

    t_work              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QCNT_W-1:0]  r_cnt;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// ----- hw/rtl/segi_back.sv -----
// ----------------------------------------------------------------------------
// segi_back: divider pipeline
// Restoring division of both numerators by the denominator, one quotient bit
// per stage, with the last stage acting as the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_en,
    input  wire                            i_valid,
    input  segi_pkg::t_work                i_work,
    output logic                           o_valid,
    output logic                           o_hit,
    output logic [segi_pkg::COORD_BITS-1:0] o_x,
    output logic [segi_pkg::COORD_BITS-1:0] o_y
);
    import segi_pkg::*;

    localparam int C = COORD_BITS;

    logic              r_v   [C+1];
    logic              r_hit [C+1];
    logic [NUM_W-1:0]  r_rx  [C+1];
    logic [NUM_W-1:0]  r_ry  [C+1];
    logic [DMAG_W-1:0] r_den [C+1];
    logic [C-1:0]      r_qx  [C+1];
    logic [C-1:0]      r_qy  [C+1];

    logic [NUM_W:0]    n_tx  [C];
    logic [NUM_W:0]    n_ty  [C];

    // Trial subtraction of the shifted denominator at every stage.
    always_comb begin
        for (int k = 0; k < C; k++) begin
            n_tx[k] = {1'b0, r_rx[k]} - ((NUM_W+1)'(r_den[k]) << (C - 1 - k));
            n_ty[k] = {1'b0, r_ry[k]} - ((NUM_W+1)'(r_den[k]) << (C - 1 - k));
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= C; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < C; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    // Division stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit[0] <= i_work.hit;
            r_rx[0]  <= i_work.num_x;
            r_ry[0]  <= i_work.num_y;
            r_den[0] <= i_work.den;
            r_qx[0]  <= '0;
            r_qy[0]  <= '0;
            for (int k = 0; k < C; k++) begin
                r_hit[k+1] <= r_hit[k];
                r_den[k+1] <= r_den[k];
                r_rx[k+1]  <= n_tx[k][NUM_W] ? r_rx[k] : n_tx[k][NUM_W-1:0];
                r_ry[k+1]  <= n_ty[k][NUM_W] ? r_ry[k] : n_ty[k][NUM_W-1:0];
                r_qx[k+1]  <= r_qx[k] | (C'(!n_tx[k][NUM_W]) << (C - 1 - k));
                r_qy[k+1]  <= r_qy[k] | (C'(!n_ty[k][NUM_W]) << (C - 1 - k));
            end
        end
    end

    // A miss reports zero coordinates.
    assign o_valid = r_v[C];
    assign o_hit   = r_hit[C];
    assign o_x     = r_hit[C] ? r_qx[C] : '0;
    assign o_y     = r_hit[C] ? r_qy[C] : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/segment_intersection.sv -----
// ----------------------------------------------------------------------------
// segment_intersection: pipelined line segment crossing test
// Top level joining the classifier front end, the work queue and the divider.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries two segments (eight coordinates); the output
//   channel carries one result per pair: a hit flag and the crossing point,
//   truncated toward zero, with zero coordinates on a miss.
//   Both channels use valid and stall; a transfer happens on a rising edge
//   with valid high and stall low.
//   Throughput is one pair per cycle while neither channel stalls. A pair
//   passes the classifier stages, a register in the queue and the
//   divider stages; the divider takes one quotient bit per stage.
//   When the receiver stalls, the divider pipeline holds; the 4-entry queue
//   absorbs what the classifier still produces, and o_stall rises only once
//   the queue is full.
//   Reset (synchronous, active low) empties all pipelines and the queue;
//   there is no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire [segi_pkg::COORD_BITS-1:0] i_seg_a_start_x,
    input  wire [segi_pkg::COORD_BITS-1:0] i_seg_a_end_x,
    input  wire [segi_pkg::COORD_BITS-1:0] i_seg_a_start_y,
    input  wire [segi_pkg::COORD_BITS-1:0] i_seg_a_end_y,
    input  wire [segi_pkg::COORD_BITS-1:0] i_seg_b_start_x,
    input  wire [segi_pkg::COORD_BITS-1:0] i_seg_b_end_x,
    input  wire [segi_pkg::COORD_BITS-1:0] i_seg_b_start_y,
    input  wire [segi_pkg::COORD_BITS-1:0] i_seg_b_end_y,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic                           o_hit,
    output logic [segi_pkg::COORD_BITS-1:0] o_cross_x,
    output logic [segi_pkg::COORD_BITS-1:0] o_cross_y
);
    import segi_pkg::*;

    logic  front_en, front_valid, q_full, q_empty, back_en, q_pop;
    t_work front_work, q_work;

    // The front advances while the queue has room; the back while its output
    // is empty or being taken.
    assign front_en = !q_full;
    assign back_en  = !o_valid || !i_stall;
    assign q_pop    = back_en && !q_empty;
    assign o_stall  = q_full;

    segi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (front_en),
        .i_valid (i_valid),
        .i_ax1   (i_seg_a_start_x),
        .i_ax2   (i_seg_a_end_x),
        .i_ay1   (i_seg_a_start_y),
        .i_ay2   (i_seg_a_end_y),
        .i_bx1   (i_seg_b_start_x),
        .i_bx2   (i_seg_b_end_x),
        .i_by1   (i_seg_b_start_y),
        .i_by2   (i_seg_b_end_y),
        .o_valid (front_valid),
        .o_work  (front_work)
    );

    segi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_en && front_valid),
        .i_data  (front_work),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_work)
    );

    segi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (back_en),
        .i_valid (q_pop),
        .i_work  (q_work),
        .o_valid (o_valid),
        .o_hit   (o_hit),
        .o_x     (o_cross_x),
        .o_y     (o_cross_y)
    );

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_cross_x == '0 && o_cross_y == '0))
        else $error("miss reported with nonzero point");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hit) && $stable(o_cross_x)))
        else $error("stalled result changed");
    a_stall_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> q_full)
        else $error("input stalled with room in the queue");

endmodule

`default_nettype wire
